[src/vrp_pkg.sv]
// Package with constants, types and trig table helpers for the vertex rotate and project block.
package vrp_pkg;

   // Datapath widths.
   localparam int COORD_BITS = 18;
   localparam int TRIG_BITS  = 16;
   localparam int DIV_BITS   = 28;
   localparam int REM_BITS   = 20;
   localparam int MAX_DIM    = 256;
   localparam int DIM_BITS   = 9;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_ANGLE_X  = 3'd0,
      REG_ANGLE_Y  = 3'd1,
      REG_ANGLE_Z  = 3'd2,
      REG_CAM_DIST = 3'd3,
      REG_WIDTH    = 3'd4,
      REG_HEIGHT   = 3'd5
   } reg_index_type;

   typedef logic [14:0] sine_tab_type [0:90];

   // Unsigned quotient by shift and subtract, used only while building the table.
   function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // Integer Taylor evaluation of sin(d degrees) in Q1.14, used at elaboration.
   function automatic logic [14:0] sine_quarter(int unsigned d);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned sum;
      x = longint'(d) * 64'd18740330;
      x2 = (x * x) >> 30;
      t = x;
      sum = x;
      for (int k = 1; k <= 6; k++) begin
         t = udiv64((t * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
         if (k[0] == 1'b1) begin
            sum = sum - t;
         end else begin
            sum = sum + t;
         end
      end
      sum = (sum + 64'd32768) >> 16;
      if (sum > 64'd16384) begin
         sum = 64'd16384;
      end
      return sum[14:0];
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      for (int d = 0; d <= 90; d++) begin
         tab[d] = sine_quarter(d);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   // Reduce an angle below 450 into 0..359.
   function automatic logic [8:0] mod360(logic [9:0] v);
      logic [9:0] r;
      r = (v >= 10'd360) ? (v - 10'd360) : v;
      return r[8:0];
   endfunction

   // Full-wave sine from the quarter table, angle in 0..359.
   function automatic logic signed [TRIG_BITS-1:0] sine_deg(logic [8:0] d);
      logic [8:0] f;
      logic neg;
      logic signed [TRIG_BITS-1:0] mag;
      if (d <= 9'd90) begin
         f = d;
         neg = 1'b0;
      end else if (d <= 9'd180) begin
         f = 9'd180 - d;
         neg = 1'b0;
      end else if (d <= 9'd270) begin
         f = d - 9'd180;
         neg = 1'b1;
      end else begin
         f = 9'd360 - d;
         neg = 1'b1;
      end
      mag = {1'b0, SINE_TAB[f[6:0]]};
      return neg ? -mag : mag;
   endfunction

   // Clamp a screen dimension into 1..MAX_DIM.
   function automatic logic [DIM_BITS-1:0] clamp_dim(logic [DIM_BITS-1:0] v);
      if (v == '0) begin
         return DIM_BITS'(1);
      end else if (v > DIM_BITS'(MAX_DIM)) begin
         return DIM_BITS'(MAX_DIM);
      end
      return v;
   endfunction

   // Payload carried through the divider pipeline.
   typedef struct packed {
      logic [REM_BITS-1:0] rem_col;
      logic [DIV_BITS-1:0] nq_col;
      logic [REM_BITS-1:0] rem_row;
      logic [DIV_BITS-1:0] nq_row;
      logic [REM_BITS-1:0] divisor;
      logic                neg_col;
      logic                neg_row;
      logic                depth_pos;
      logic [2:0]          id;
   } div_stage_type;

endpackage

[src/vertex_rotate_project.sv]
// Top level: rotates a vertex by three configured angles and projects it to a screen position.
//
//  Channel  Direction  Handshake             Contents
//  req      in         req_tvalid/tready     vertex x, y, z (Q3.12) and vertex number
//  rsp      out        rsp_tvalid/tready     screen index, column, row, label; tuser = valid
//  csr      in         APB psel/penable      angles, camera distance, screen size
//
// One vertex is accepted every cycle while the result side is not stalled.
// The divider is a 28-stage restoring divider, one quotient bit per stage.
// Reset clears all valid bits and loads the register reset values.
// A stall on the result side holds the whole pipeline; nothing is dropped or repeated.
module vertex_rotate_project
   import vrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // vertex_x, vertex_y, vertex_z, vertex_id, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // screen_index, pixel_col, pixel_row, label_id, zero fill
   output logic        rsp_tuser,   // point_valid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers.
   logic [8:0]  angle_x_ff, angle_y_ff, angle_z_ff;
   logic [15:0] cam_dist_ff;
   logic [8:0]  width_ff, height_ff;
   logic        csr_wr;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff  <= '0;
         angle_y_ff  <= '0;
         angle_z_ff  <= '0;
         cam_dist_ff <= 16'd20480;
         width_ff    <= 9'd80;
         height_ff   <= 9'd25;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ANGLE_X:  angle_x_ff  <= csr_pwdata[8:0];
            REG_ANGLE_Y:  angle_y_ff  <= csr_pwdata[8:0];
            REG_ANGLE_Z:  angle_z_ff  <= csr_pwdata[8:0];
            REG_CAM_DIST: cam_dist_ff <= csr_pwdata[15:0];
            REG_WIDTH:    width_ff    <= csr_pwdata[8:0];
            REG_HEIGHT:   height_ff   <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (csr_idx)
         REG_ANGLE_X:  csr_prdata = {23'd0, angle_x_ff};
         REG_ANGLE_Y:  csr_prdata = {23'd0, angle_y_ff};
         REG_ANGLE_Z:  csr_prdata = {23'd0, angle_z_ff};
         REG_CAM_DIST: csr_prdata = {16'd0, cam_dist_ff};
         REG_WIDTH:    csr_prdata = {23'd0, width_ff};
         REG_HEIGHT:   csr_prdata = {23'd0, height_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // Sine and cosine of each angle; the user must keep the registers static while items are in flight (not enforced).
   logic [8:0] ax, ay, az;
   logic signed [TRIG_BITS-1:0] sx, cx, sy, cy, sz, cz;
   logic [DIM_BITS-1:0] w_clamp, h_clamp;
   logic [7:0]  w_m1, h_m1;
   logic [17:0] screen_area;

   always_comb begin
      ax = mod360({1'b0, angle_x_ff});
      ay = mod360({1'b0, angle_y_ff});
      az = mod360({1'b0, angle_z_ff});
      sx = sine_deg(ax);
      cx = sine_deg(mod360({1'b0, ax} + 10'd90));
      sy = sine_deg(ay);
      cy = sine_deg(mod360({1'b0, ay} + 10'd90));
      sz = sine_deg(az);
      cz = sine_deg(mod360({1'b0, az} + 10'd90));
      w_clamp = clamp_dim(width_ff);
      h_clamp = clamp_dim(height_ff);
      w_m1 = 8'(w_clamp - 9'd1);
      h_m1 = 8'(h_clamp - 9'd1);
      screen_area = 18'(w_clamp) * 18'(h_clamp);
   end

   // Two products summed and rounded half up from Q.26 back to Q.12.
   function automatic logic signed [COORD_BITS-1:0] mac_round(
      logic signed [COORD_BITS-1:0] p0, logic signed [TRIG_BITS-1:0] q0,
      logic signed [COORD_BITS-1:0] p1, logic signed [TRIG_BITS-1:0] q1);
      logic signed [34:0] m0;
      logic signed [34:0] m1;
      logic signed [34:0] acc;
      m0 = 35'(p0) * 35'(q0);
      m1 = 35'(p1) * 35'(q1);
      acc = m0 + m1 + 35'sd8192;
      return acc[31:14];
   endfunction

   // Pipeline advances whenever the output register is free or being emptied.
   logic adv;
   logic out_v_ff;
   assign adv = ~out_v_ff | rsp_tready;
   assign req_tready = adv;

   // Rotation about x.
   logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
   logic v1_ff;
   logic signed [COORD_BITS-1:0] x1_ff, y1_ff, z1_ff;
   logic [2:0] id1_ff;

   assign in_x = COORD_BITS'(signed'(req_tdata[15:0]));
   assign in_y = COORD_BITS'(signed'(req_tdata[31:16]));
   assign in_z = COORD_BITS'(signed'(req_tdata[47:32]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff  <= in_x;
         y1_ff  <= mac_round(in_y, cx, in_z, -sx);
         z1_ff  <= mac_round(in_y, sx, in_z, cx);
         id1_ff <= req_tdata[50:48];
      end
   end

   // Rotation about y.
   logic v2_ff;
   logic signed [COORD_BITS-1:0] x2_ff, y2_ff, z2_ff;
   logic [2:0] id2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x2_ff  <= mac_round(x1_ff, cy, z1_ff, sy);
         y2_ff  <= y1_ff;
         z2_ff  <= mac_round(z1_ff, cy, x1_ff, -sy);
         id2_ff <= id1_ff;
      end
   end

   // Rotation about z.
   logic v3_ff;
   logic signed [COORD_BITS-1:0] x3_ff, y3_ff, z3_ff;
   logic [2:0] id3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x3_ff  <= mac_round(x2_ff, cz, y2_ff, -sz);
         y3_ff  <= mac_round(x2_ff, sz, y2_ff, cz);
         z3_ff  <= z2_ff;
         id3_ff <= id2_ff;
      end
   end

   // Depth offset and projection numerators, split into sign and magnitude.
   logic signed [18:0] zc;
   logic signed [19:0] num_col_sum, num_row_sum;
   logic signed [28:0] num_col, num_row;
   div_stage_type div_in;

   always_comb begin
      zc = 19'(z3_ff) + signed'({3'b000, cam_dist_ff});
      num_col_sum = 20'(x3_ff) + 20'(zc);
      num_row_sum = 20'(zc) - (20'(y3_ff) <<< 1);
      num_col = 29'(num_col_sum) * 29'(signed'({1'b0, w_m1}));
      num_row = 29'(num_row_sum) * 29'(signed'({1'b0, h_m1}));
      div_in.rem_col   = '0;
      div_in.rem_row   = '0;
      div_in.neg_col   = num_col[28];
      div_in.neg_row   = num_row[28];
      div_in.nq_col    = DIV_BITS'(num_col[28] ? -num_col : num_col);
      div_in.nq_row    = DIV_BITS'(num_row[28] ? -num_row : num_row);
      div_in.divisor   = REM_BITS'({zc, 1'b0});
      div_in.depth_pos = (zc > 19'sd0);
      div_in.id        = id3_ff;
   end

   // One restoring division step: bring in the next numerator bit, shift in a quotient bit.
   function automatic logic [REM_BITS+DIV_BITS-1:0] div_step(
      logic [REM_BITS-1:0] rem, logic [DIV_BITS-1:0] nq, logic [REM_BITS-1:0] d);
      logic [REM_BITS:0] trial;
      logic [REM_BITS-1:0] rem_next;
      logic bit_q;
      trial = {rem, nq[DIV_BITS-1]};
      bit_q = (trial >= {1'b0, d});
      rem_next = bit_q ? REM_BITS'(trial - {1'b0, d}) : trial[REM_BITS-1:0];
      return {rem_next, nq[DIV_BITS-2:0], bit_q};
   endfunction

   // Divider pipeline, one quotient bit of both divisions per stage.
   div_stage_type dp_ff [0:DIV_BITS];
   div_stage_type dp_in [1:DIV_BITS];
   logic          dv_ff [0:DIV_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_BITS; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= v3_ff;
         for (int k = 0; k < DIV_BITS; k++) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end
   end

   // Next value of each divider stage.
   always_comb begin
      for (int k = 0; k < DIV_BITS; k++) begin
         dp_in[k+1] = dp_ff[k];
         {dp_in[k+1].rem_col, dp_in[k+1].nq_col} =
            div_step(dp_ff[k].rem_col, dp_ff[k].nq_col, dp_ff[k].divisor);
         {dp_in[k+1].rem_row, dp_in[k+1].nq_row} =
            div_step(dp_ff[k].rem_row, dp_ff[k].nq_row, dp_ff[k].divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dp_ff[0] <= div_in;
         for (int k = 0; k < DIV_BITS; k++) begin
            dp_ff[k+1] <= dp_in[k+1];
         end
      end
   end

   // Restore sign and saturate to 16 bits.
   div_stage_type dq;
   logic signed [DIV_BITS:0] q_col, q_row;
   logic signed [15:0] col_sat, row_sat;
   logic fits;
   logic v5_ff;
   logic signed [15:0] col5_ff, row5_ff;
   logic fits5_ff, dpos5_ff;
   logic [2:0] id5_ff;

   always_comb begin
      dq = dp_ff[DIV_BITS];
      q_col = signed'({1'b0, dq.nq_col});
      q_row = signed'({1'b0, dq.nq_row});
      if (dq.neg_col) q_col = -q_col;
      if (dq.neg_row) q_row = -q_row;
      fits = 1'b1;
      if (q_col > 29'sd32767) begin
         col_sat = 16'sh7FFF;
         fits = 1'b0;
      end else if (q_col < -29'sd32768) begin
         col_sat = -16'sh8000;
         fits = 1'b0;
      end else begin
         col_sat = q_col[15:0];
      end
      if (q_row > 29'sd32767) begin
         row_sat = 16'sh7FFF;
         fits = 1'b0;
      end else if (q_row < -29'sd32768) begin
         row_sat = -16'sh8000;
         fits = 1'b0;
      end else begin
         row_sat = q_row[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= dv_ff[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         col5_ff  <= col_sat;
         row5_ff  <= row_sat;
         fits5_ff <= fits;
         dpos5_ff <= dq.depth_pos;
         id5_ff   <= dq.id;
      end
   end

   // Linear index, screen bounds check and the output register.
   logic signed [26:0] idx;
   logic idx_ok;
   logic point_valid_ff;
   logic [15:0] screen_index_ff;
   logic signed [15:0] pixel_col_ff, pixel_row_ff;
   logic [2:0] label_id_ff;

   always_comb begin
      idx = 27'(row5_ff) * 27'(signed'({1'b0, w_clamp})) + 27'(col5_ff);
      idx_ok = fits5_ff && (idx >= 27'sd0) && (idx < signed'({9'd0, screen_area}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         label_id_ff <= id5_ff;
         if (!dpos5_ff) begin
            point_valid_ff  <= 1'b0;
            screen_index_ff <= '0;
            pixel_col_ff    <= '0;
            pixel_row_ff    <= '0;
         end else begin
            point_valid_ff  <= idx_ok;
            screen_index_ff <= idx_ok ? idx[15:0] : 16'd0;
            pixel_col_ff    <= col5_ff;
            pixel_row_ff    <= row5_ff;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = point_valid_ff;
   assign rsp_tdata  = {5'd0, label_id_ff, pixel_row_ff, pixel_col_ff, screen_index_ff};

endmodule

[bench/tb_vertex_rotate_project.sv]
// Self-checking testbench for the vertex rotate and project block.
module tb_vertex_rotate_project
   import vrp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   vertex_rotate_project DUT (.*);

   always #5 clock = ~clock;

   // One projected point as it leaves the block.
   typedef struct packed {
      logic        on_screen;
      logic [15:0] index;
      logic [15:0] col;
      logic [15:0] row;
      logic [2:0]  label;
   } point_type;

   // One directed row: a vertex and, where obvious, its typed-in point.
   typedef struct {
      logic signed [15:0] vx, vy, vz;
      logic [2:0]         id;
      bit                 typed;
      point_type          pt;
   } vec_row_type;

   point_type   pending_points[$];
   int          errors = 0;
   bit          quiet_phase = 0;
   logic [8:0]  ang_x = 0, ang_y = 0, ang_z = 0, scr_w = 80, scr_h = 25;
   logic [15:0] cam_dist = 16'd20480;

   // Quarter-wave sine in Q1.14 from a fixed-point Taylor series.
   function automatic longint quarter_sine(int unsigned d);
      longint unsigned x, x2, t, acc;
      x = 64'(d) * 64'd18740330;
      x2 = (x * x) >> 30;
      t = x;
      acc = x;
      for (int k = 1; k <= 6; k++) begin
         t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         acc = (k % 2) ? acc - t : acc + t;
      end
      acc = (acc + 64'd32768) >> 16;
      return (acc > 16384) ? 16384 : longint'(acc);
   endfunction

   function automatic longint sine_of(int unsigned d);
      d = d % 360;
      if (d <= 90) return quarter_sine(d);
      if (d <= 180) return quarter_sine(180 - d);
      if (d <= 270) return -quarter_sine(d - 180);
      return -quarter_sine(360 - d);
   endfunction

   // Round Q.26 back to Q.12, half up.
   function automatic longint round_half_up(longint v);
      v += 8192;
      return (v >= 0) ? (v >>> 14) : -((-v + 16383) >>> 14);
   endfunction

   function automatic longint dim_limit(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return longint'(v);
   endfunction

   function automatic longint clip16(longint v, ref bit fits);
      if (v > 32767) begin fits = 0; return 32767; end
      if (v < -32768) begin fits = 0; return -32768; end
      return v;
   endfunction

   // Rotate about X, Y, Z, then project onto the screen.
   function automatic point_type project_vertex(logic signed [15:0] vx, vy, vz,
                                                 logic [2:0] id);
      longint x, y, z, s, c, a, b, zc, w, h, col, row, idx;
      bit fits;
      point_type p;
      x = vx; y = vy; z = vz;
      fits = 1;
      p = '0;
      p.label = id;
      s = sine_of(ang_x % 360); c = sine_of(ang_x % 360 + 90);
      a = round_half_up(y * c - z * s); b = round_half_up(y * s + z * c);
      y = a; z = b;
      s = sine_of(ang_y % 360); c = sine_of(ang_y % 360 + 90);
      a = round_half_up(x * c + z * s); b = round_half_up(z * c - x * s);
      x = a; z = b;
      s = sine_of(ang_z % 360); c = sine_of(ang_z % 360 + 90);
      a = round_half_up(x * c - y * s); b = round_half_up(x * s + y * c);
      x = a; y = b;
      zc = z + longint'(cam_dist);
      if (zc <= 0) return p;
      w = dim_limit(scr_w);
      h = dim_limit(scr_h);
      col = ((x + zc) * (w - 1)) / (2 * zc);
      row = ((zc - 2 * y) * (h - 1)) / (2 * zc);
      idx = row * w + col;
      col = clip16(col, fits);
      row = clip16(row, fits);
      p.on_screen = fits && idx >= 0 && idx < w * h;
      p.index = p.on_screen ? idx[15:0] : 16'd0;
      p.col = col[15:0];
      p.row = row[15:0];
      return p;
   endfunction

   // Register write: setup cycle, then access cycle.
   task automatic write_reg(reg_index_type r, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= 5'(r) << 2; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (r)
         REG_ANGLE_X:  ang_x = v[8:0];
         REG_ANGLE_Y:  ang_y = v[8:0];
         REG_ANGLE_Z:  ang_z = v[8:0];
         REG_CAM_DIST: cam_dist = v[15:0];
         REG_WIDTH:    scr_w = v[8:0];
         REG_HEIGHT:   scr_h = v[8:0];
         default: ;
      endcase
   endtask

   task automatic set_view(int ax, int ay, int az, int cd, int w, int h);
      write_reg(REG_ANGLE_X, ax);
      write_reg(REG_ANGLE_Y, ay);
      write_reg(REG_ANGLE_Z, az);
      write_reg(REG_CAM_DIST, cd);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   // Wait until every point has come back, plus pipeline slack.
   task automatic drain_points();
      while (pending_points.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Send one vertex transaction, at random with an idle burst before it outside the quiet phase.
   task automatic send_vertex(logic signed [15:0] vx, vy, vz, logic [2:0] id,
                              bit typed, point_type pt);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'b0, id, vz, vy, vx};
      pending_points.push_back(typed ? pt : project_vertex(vx, vy, vz, id));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Result side: random stall bursts and field-by-field compare.
   initial begin
      point_type want, got;
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                   rsp_tdata[50:48]};
            if (pending_points.size() == 0) begin
               errors++;
               $display("%0t: unexpected point %h", $time, got);
            end else begin
               want = pending_points.pop_front();
               if (got.on_screen !== want.on_screen || got.index !== want.index ||
                   got.col !== want.col || got.row !== want.row ||
                   got.label !== want.label) begin
                  errors++;
                  $display("%0t: point mismatch expected %h actual %h", $time, want, got);
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= (stall == 0);
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 16);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // Timeout guard.
   initial begin
      #5ms;
      $display("vertex_rotate_project verification failed");
      $finish;
   end

   // Main stimulus.
   initial begin
      vec_row_type rows[$];
      point_type   none;
      int          hi_sel;
      none = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed rows at the reset view: origin maps to the screen center.
      rows.push_back('{0, 0, 0, 0, 1, '{1, 16'd12*80 + 39, 16'd39, 16'd12, 3'd0}});
      rows.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 7, 0, none});
      rows.push_back('{-16'sh8000, -16'sh8000, -16'sh8000, 5, 0, none});
      rows.push_back('{16'sh7FFF, -16'sh8000, 0, 2, 0, none});
      rows.push_back('{-16'sh8000, 16'sh7FFF, 4096, 3, 0, none});
      // Depth pulled to zero: camera 5.0, z = -5.0, nothing on screen.
      rows.push_back('{100, 100, -20480, 6, 1, '{0, 0, 0, 0, 3'd6}});
      rows.push_back('{0, 0, -32768, 1, 1, '{0, 0, 0, 0, 3'd1}});
      rows.push_back('{-16'sh5555, 16'sh2AAA, -16'sh2AAA, 4, 0, none});
      foreach (rows[i])
         send_vertex(rows[i].vx, rows[i].vy, rows[i].vz, rows[i].id, rows[i].typed,
                     rows[i].pt);
      req_tvalid <= 0;
      drain_points();

      // Extreme views (angles past 360, tiny camera distance, odd screen sizes), then random views.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: set_view(90, 180, 270, 1, 0, 0);
            1: set_view(511, 360, 359, 65535, 511, 511);
            2: set_view(45, 0, 0, 0, 256, 256);
            3: set_view(0, 0, 0, 4096, 1, 1);
            default: set_view($urandom_range(0, 511), $urandom_range(0, 511),
                               $urandom_range(0, 511),
                               $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(4096, 40960),
                               $urandom_range(0, 511), $urandom_range(0, 511));
         endcase
         if (ph == 11) quiet_phase = 1;
         repeat (ph < 4 ? 20 : 140) begin
            hi_sel = $urandom_range(0, 3);
            if (hi_sel == 0)
               send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom),
                           0, none);
            else
               send_vertex(16'($urandom_range(0, 16383) - 8192),
                           16'($urandom_range(0, 16383) - 8192),
                           16'($urandom_range(0, 16383) - 8192), 3'($urandom), 0, none);
         end
         req_tvalid <= 0;
         drain_points();
      end

      if (errors == 0)
         $display("vertex_rotate_project verification clean");
      else
         $display("vertex_rotate_project verification failed");
      $finish;
   end
endmodule
